// ===== hw/rtl/length_checked_packet_deframer_unit_macros.svh =====
//------------------------------------------------------------------------------
// Assertion macros for the packet deframer
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
//------------------------------------------------------------------------------
`ifndef LENGTH_CHECKED_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_CHECKED_PACKET_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication
`define LCPD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcpd assertion failed");

// Next-cycle implication
`define LCPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcpd assertion failed");

`endif

// ===== hw/rtl/lcpd_pkg.sv =====
//------------------------------------------------------------------------------
// Packet deframer package
// Widths and header constants for the length-checked packet deframer.
//------------------------------------------------------------------------------
`default_nettype none

package lcpd_pkg;

	localparam int unsigned BYTE_W = 8;

	// length plus check must equal this for a good header
	localparam logic [BYTE_W:0] HDR_SUM = 9'd255;

	typedef logic [BYTE_W-1:0] byte_t;

	// one result transaction
	typedef struct packed {
		byte_t pkt_type;
		byte_t pkt_code;
		byte_t pkt_length;
		byte_t byte_index;
		byte_t payload_byte;
		logic  empty_packet;
		logic  last;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/length_checked_packet_deframer_unit.sv =====
//------------------------------------------------------------------------------
// Length-checked packet deframer
// Hunts for a preamble byte, checks a type/code/length/check header and
// streams the payload bytes out tagged with header fields and position.
//------------------------------------------------------------------------------
// The block takes one received byte per cycle while its result slot is free;
// while a result waits for out_ready, the registered byte and the input stall.
// A byte is registered on acceptance; the framing state machine then updates
// and, if the byte yields a result, loads the output register.
// Each byte needs a single phase update, which sets the one-byte-per-cycle
// rate. Bytes that do not match the preamble while hunting, header bytes, and
// headers whose length plus check is not 255 produce no result. A header with
// length zero gives one result flagged empty and last. The preamble register
// should be written only while no bytes are in flight.
`default_nettype none

module length_checked_packet_deframer_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire lcpd_pkg::byte_t       cfg_data,
	// received byte
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire lcpd_pkg::byte_t       rx_byte,
	// result
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output lcpd_pkg::byte_t            pkt_type,
	output lcpd_pkg::byte_t            pkt_code,
	output lcpd_pkg::byte_t            pkt_length,
	output lcpd_pkg::byte_t            byte_index,
	output lcpd_pkg::byte_t            payload_byte,
	output logic                       empty_packet,
	output logic                       last
);

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_TYPE   = 3'd1,
		PH_CODE   = 3'd2,
		PH_LENGTH = 3'd3,
		PH_CHECK  = 3'd4,
		PH_DATA   = 3'd5
	} phase_t;

	phase_t              phase_q;
	lcpd_pkg::byte_t     preamble_q;
	lcpd_pkg::byte_t     held_type_q;
	lcpd_pkg::byte_t     held_code_q;
	lcpd_pkg::byte_t     held_length_q;
	lcpd_pkg::byte_t     received_count_q;
	lcpd_pkg::result_t   result_q;
	logic                out_valid_q;

	logic                valid_s1;
	lcpd_pkg::byte_t     byte_s1;

	logic                slot_free;
	logic                proc_fire;
	logic                proc_emit;
	logic [lcpd_pkg::BYTE_W:0] hdr_sum;
	logic                hdr_ok;
	lcpd_pkg::byte_t     count_inc;
	logic                data_fin;

	// configuration is always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			preamble_q <= cfg_data;
		end
	end

	// handshake: byte in stage 1 is processed when the result slot is free
	assign slot_free = !out_valid_q || out_ready;
	assign proc_fire = valid_s1 && slot_free;
	assign in_ready  = !valid_s1 || proc_fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				byte_s1 <= rx_byte;
			end
		end
	end

	// header check and payload position
	assign hdr_sum   = {1'b0, held_length_q} + {1'b0, byte_s1};
	assign hdr_ok    = (hdr_sum == lcpd_pkg::HDR_SUM);
	assign count_inc = received_count_q + lcpd_pkg::byte_t'(1);
	assign data_fin  = (count_inc == held_length_q);

	// a processed byte yields a result: payload byte or empty packet
	assign proc_emit = proc_fire && ((phase_q == PH_DATA) ||
		((phase_q == PH_CHECK) && hdr_ok && (held_length_q == '0)));

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// framing state machine and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_HUNT;
			held_type_q      <= '0;
			held_code_q      <= '0;
			held_length_q    <= '0;
			received_count_q <= '0;
			result_q         <= '0;
		end else begin
			if (proc_fire) begin
				unique case (phase_q)
					PH_TYPE: begin
						held_type_q <= byte_s1;
						phase_q     <= PH_CODE;
					end
					PH_CODE: begin
						held_code_q <= byte_s1;
						phase_q     <= PH_LENGTH;
					end
					PH_LENGTH: begin
						held_length_q <= byte_s1;
						phase_q       <= PH_CHECK;
					end
					PH_CHECK: begin
						if (!hdr_ok) begin
							phase_q <= PH_HUNT;
						end else if (held_length_q == '0) begin
							// empty packet: one flagged result
							phase_q               <= PH_HUNT;
							result_q.pkt_type     <= held_type_q;
							result_q.pkt_code     <= held_code_q;
							result_q.pkt_length   <= held_length_q;
							result_q.byte_index   <= '0;
							result_q.payload_byte <= '0;
							result_q.empty_packet <= 1'b1;
							result_q.last         <= 1'b1;
						end else begin
							received_count_q <= '0;
							phase_q          <= PH_DATA;
						end
					end
					PH_DATA: begin
						received_count_q      <= count_inc;
						if (data_fin) begin
							phase_q <= PH_HUNT;
						end
						result_q.pkt_type     <= held_type_q;
						result_q.pkt_code     <= held_code_q;
						result_q.pkt_length   <= held_length_q;
						result_q.byte_index   <= received_count_q;
						result_q.payload_byte <= byte_s1;
						result_q.empty_packet <= 1'b0;
						result_q.last         <= data_fin;
					end
					default: begin
						// hunting; unused codes behave the same
						phase_q <= (byte_s1 == preamble_q) ? PH_TYPE : PH_HUNT;
					end
				endcase
			end
		end
	end

	// result outputs
	assign out_valid    = out_valid_q;
	assign pkt_type     = result_q.pkt_type;
	assign pkt_code     = result_q.pkt_code;
	assign pkt_length   = result_q.pkt_length;
	assign byte_index   = result_q.byte_index;
	assign payload_byte = result_q.payload_byte;
	assign empty_packet = result_q.empty_packet;
	assign last         = result_q.last;

	// checks
`include "length_checked_packet_deframer_unit_macros.svh"

	`LCPD_ASSERT_SAME(a_empty_is_last, out_valid && empty_packet, last && (pkt_length == '0))
	`LCPD_ASSERT_SAME(a_last_at_end, out_valid && last && !empty_packet,
		(byte_index + 8'd1) == pkt_length)
	`LCPD_ASSERT_SAME(a_data_nonzero_len, phase_q == PH_DATA, held_length_q != '0)
	`LCPD_ASSERT_NEXT(a_bad_hdr_resync, proc_fire && (phase_q == PH_CHECK) && !hdr_ok,
		phase_q == PH_HUNT)

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Length-checked packet deframer testbench
// Drives received bytes into the deframer and predicts each tagged payload
// transaction from a shadow copy of the framing state. A single monitor
// checks every output transaction against the oldest prediction. The run
// covers directed header cases, a long output hold-off, and random traffic
// under several preamble settings, mostly with bursty input and stalling output.
//------------------------------------------------------------------------------

module testbench;

	localparam int HOLD_CYCLES = 400;   // long output hold-off
	localparam int PIPE_LAT    = 8;     // settle time after last result
	localparam int STUCK_LIMIT = 5000;  // cycles with no transaction at all

	typedef enum logic [2:0] {
		HUNT, HDR_TYPE, HDR_CODE, HDR_LEN, HDR_CHECK, PAYLOAD
	} frame_phase_e;

	typedef enum logic [1:0] {RX_OPEN, RX_PATTERN, RX_RANDOM} rx_mode_e;

	logic            clk          = 1'b0;
	logic            arst_n       = 1'b0;
	logic            cfg_valid    = 1'b0;
	lcpd_pkg::byte_t cfg_data     = '0;
	logic            in_valid     = 1'b0;
	lcpd_pkg::byte_t rx_byte      = '0;
	logic            out_ready    = 1'b0;
	logic            cfg_ready;
	logic            in_ready;
	logic            out_valid;
	lcpd_pkg::byte_t pkt_type;
	lcpd_pkg::byte_t pkt_code;
	lcpd_pkg::byte_t pkt_length;
	lcpd_pkg::byte_t byte_index;
	lcpd_pkg::byte_t payload_byte;
	logic            empty_packet;
	logic            last;

	// shadow framing state
	frame_phase_e      phase_q    = HUNT;
	lcpd_pkg::byte_t   preamble_q = '0;
	lcpd_pkg::byte_t   type_q     = '0;
	lcpd_pkg::byte_t   code_q     = '0;
	lcpd_pkg::byte_t   len_q      = '0;
	lcpd_pkg::byte_t   count_q    = '0;
	lcpd_pkg::result_t deframed_q[$];

	// stimulus control
	bit       gaps_on    = 1'b0;
	int       burst_left = 0;
	rx_mode_e rx_mode    = RX_OPEN;
	bit       hold_req   = 1'b0;
	int       hold_left  = 0;
	logic [15:0] rx_pat  = 16'hB3D5;
	logic [5:0]  rx_tick = '0;

	// statistics
	int framed_items  = 0;
	int mismatches    = 0;
	int results_seen  = 0;
	int empties_seen  = 0;
	int ends_seen     = 0;
	int bad_headers   = 0;
	int preamble_sets = 0;

	length_checked_packet_deframer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pkt_type     (pkt_type),
		.pkt_code     (pkt_code),
		.pkt_length   (pkt_length),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.empty_packet (empty_packet),
		.last         (last)
	);

	initial forever #1 clk = ~clk;

	// Framing prediction: advance the shadow state by one byte and queue
	// the tagged payload transaction it yields, if any.
	function automatic void track_framing(input lcpd_pkg::byte_t b);
		lcpd_pkg::result_t r;
		r = '0;
		case (phase_q)
			HDR_TYPE: begin
				type_q  = b;
				phase_q = HDR_CODE;
			end
			HDR_CODE: begin
				code_q  = b;
				phase_q = HDR_LEN;
			end
			HDR_LEN: begin
				len_q   = b;
				phase_q = HDR_CHECK;
			end
			HDR_CHECK: begin
				if ({1'b0, len_q} + {1'b0, b} != lcpd_pkg::HDR_SUM) begin
					bad_headers++;
					phase_q = HUNT;
				end else if (len_q == '0) begin
					// empty packet: one result, flagged empty and last
					r.pkt_type     = type_q;
					r.pkt_code     = code_q;
					r.pkt_length   = len_q;
					r.empty_packet = 1'b1;
					r.last         = 1'b1;
					deframed_q.push_back(r);
					phase_q = HUNT;
				end else begin
					count_q = '0;
					phase_q = PAYLOAD;
				end
			end
			PAYLOAD: begin
				r.pkt_type     = type_q;
				r.pkt_code     = code_q;
				r.pkt_length   = len_q;
				r.byte_index   = count_q;
				r.payload_byte = b;
				count_q        = count_q + 8'd1;
				r.last         = (count_q == len_q);
				if (r.last)
					phase_q = HUNT;
				deframed_q.push_back(r);
			end
			default: begin
				phase_q = (b == preamble_q) ? HDR_TYPE : HUNT;
			end
		endcase
	endfunction

	task automatic note_mismatch(input string what, input lcpd_pkg::result_t want,
		input lcpd_pkg::result_t got);
		if (mismatches < 10) begin
			$display("ERROR %s at %0t: expected type=%h code=%h len=%h idx=%h data=%h",
				what, $realtime, want.pkt_type, want.pkt_code, want.pkt_length,
				want.byte_index, want.payload_byte);
			$display("    expected empty=%b last=%b, got type=%h code=%h len=%h idx=%h",
				want.empty_packet, want.last, got.pkt_type, got.pkt_code,
				got.pkt_length, got.byte_index);
			$display("    got data=%h empty=%b last=%b",
				got.payload_byte, got.empty_packet, got.last);
		end
		mismatches++;
	endtask

	// Monitor: every transaction on all three channels, sampled at the edge.
	// Input bytes are predicted before output results are compared.
	always @(posedge clk) begin
		lcpd_pkg::result_t got;
		lcpd_pkg::result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				preamble_q = cfg_data;
				preamble_sets++;
			end
			if (in_valid && in_ready)
				track_framing(rx_byte);
			if (out_valid && out_ready) begin
				got = '{pkt_type, pkt_code, pkt_length, byte_index, payload_byte,
					empty_packet, last};
				results_seen++;
				if (empty_packet) empties_seen++;
				if (last) ends_seen++;
				if (deframed_q.size() == 0) begin
					note_mismatch("result with nothing pending", '0, got);
				end else begin
					want = deframed_q.pop_front();
					if (got !== want)
						note_mismatch("result mismatch", want, got);
				end
			end
		end
	end

	// Output stall pattern, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN: out_ready = 1'b1;
				RX_PATTERN: begin
					out_ready = rx_pat[0];
					rx_pat    = {rx_pat[0], rx_pat[15:1]};
					rx_tick   = rx_tick + 6'd1;
					if (rx_tick == '0)
						rx_pat = 16'($urandom) | 16'h0101;
				end
				default: out_ready = ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Watchdog: end the run if no transaction happens for too long
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("Timeout: no transaction for %0d cycles", STUCK_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// One input transaction; valid stays up across a burst
	task automatic send_byte(input lcpd_pkg::byte_t b, input bit framed);
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		rx_byte  = b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (framed) framed_items++;
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap        = $urandom_range(1, 12);
				@(negedge clk);
				in_valid = 1'b0;
				rx_byte  = lcpd_pkg::byte_t'($urandom);
				repeat (gap - 1) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_header(input lcpd_pkg::byte_t ptype, input lcpd_pkg::byte_t pcode,
		input lcpd_pkg::byte_t plen, input lcpd_pkg::byte_t check);
		send_byte(preamble_q, 1'b1);
		send_byte(ptype, 1'b1);
		send_byte(pcode, 1'b1);
		send_byte(plen, 1'b1);
		send_byte(check, 1'b1);
	endtask

	// Stop offering input and wait until all predicted results are out
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (deframed_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	task automatic write_preamble(input lcpd_pkg::byte_t value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// mostly short payloads, now and then long ones up to the maximum
	function automatic lcpd_pkg::byte_t pick_length();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 10) return 8'd0;
		if (sel < 70) return lcpd_pkg::byte_t'($urandom_range(1, 8));
		if (sel < 97) return lcpd_pkg::byte_t'($urandom_range(9, 40));
		return lcpd_pkg::byte_t'($urandom_range(41, 255));
	endfunction

	// Preamble reset value is zero: a packet framed by a zero byte
	task automatic test_reset_preamble();
		gaps_on = 1'b0;
		rx_mode = RX_OPEN;
		send_header(8'h00, 8'hFF, 8'd1, 8'hFE);
		send_byte(8'h00, 1'b1);
	endtask

	// Dropped hunt byte, empty packet, check overflow, header bytes that
	// equal the preamble
	task automatic test_header_cases();
		drain_results();
		rx_mode = RX_RANDOM;
		write_preamble(8'hA5);
		send_byte(8'hFF, 1'b0);
		send_header(8'hFF, 8'h00, 8'h00, 8'hFF);
		// 0x80 + 0x80 wraps in 8 bits but is 256, not 255
		send_header(8'h12, 8'h34, 8'h80, 8'h80);
		send_header(8'hA5, 8'hA5, 8'h02, 8'hFD);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hA5, 1'b1);
	endtask

	// Output held off while a maximum-length packet keeps coming, so the
	// block fills up and pushes back on its input
	task automatic test_output_holdoff();
		drain_results();
		rx_mode = RX_OPEN;
		gaps_on = 1'b0;
		@(posedge clk);
		hold_req = 1'b1;
		send_header(8'h3C, 8'hC3, 8'hFF, 8'h00);
		repeat (255) send_byte(lcpd_pkg::byte_t'($urandom), 1'b1);
	endtask

	// Random packets with random content, plus noise, bad checks and
	// truncated headers
	task automatic test_random_traffic(input lcpd_pkg::byte_t pre, input int items,
		input bit gaps, input rx_mode_e rxm);
		int              target;
		int              kind;
		lcpd_pkg::byte_t plen;
		drain_results();
		rx_mode    = rxm;
		gaps_on    = gaps;
		burst_left = 0;
		write_preamble(pre);
		target = framed_items + items;
		while (framed_items < target) begin
			kind = $urandom_range(0, 99);
			plen = pick_length();
			if (kind < 8) begin
				repeat ($urandom_range(1, 4))
					send_byte(lcpd_pkg::byte_t'($urandom), 1'b0);
			end else if (kind < 16) begin
				send_header(lcpd_pkg::byte_t'($urandom), lcpd_pkg::byte_t'($urandom), plen,
					~plen ^ lcpd_pkg::byte_t'($urandom_range(1, 255)));
			end else if (kind < 22) begin
				send_byte(preamble_q, 1'b1);
				repeat ($urandom_range(0, 3))
					send_byte(lcpd_pkg::byte_t'($urandom), 1'b1);
			end else begin
				send_header(lcpd_pkg::byte_t'($urandom), lcpd_pkg::byte_t'($urandom), plen,
					~plen);
				repeat (plen) send_byte(lcpd_pkg::byte_t'($urandom), 1'b1);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_preamble();
		test_header_cases();
		test_output_holdoff();
		test_random_traffic(8'hFF, 280, 1'b1, RX_PATTERN);
		test_random_traffic(8'h00, 280, 1'b0, RX_OPEN);
		test_random_traffic(lcpd_pkg::byte_t'($urandom), 280, 1'b1, RX_RANDOM);
		test_random_traffic(lcpd_pkg::byte_t'($urandom), 320, 1'b1, RX_PATTERN);
		drain_results();

		if (deframed_q.size() != 0) begin
			$display("ERROR: %0d predicted results never arrived", deframed_q.size());
			mismatches++;
		end

		$display("Covered %0d framed bytes, %0d results (%0d empty, %0d packet ends),",
			framed_items, results_seen, empties_seen, ends_seen);
		$display("%0d rejected headers, %0d preamble writes, one %0d-cycle output hold-off",
			bad_headers, preamble_sets, HOLD_CYCLES);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lcpd_pkg.sv
hw/rtl/length_checked_packet_deframer_unit.sv
tb/sv/testbench.sv
